// ----- sv/ssmt_pkg.sv -----
// Shared types and constants for the sorted sparse matrix table.
// Used by sorted_sparse_matrix_table; depends on nothing.
package ssmt_pkg;

   // Default geometry of the table
   localparam int TableDepthDefault = 256;
   localparam int IndexWidthDefault = 20;
   localparam int ValueWidthDefault = 32;

   // Configuration port
   localparam int CountWidth    = 21;
   localparam int CsrDataWidth  = 32;
   localparam int CsrIndexWidth = 2;

   localparam logic [CountWidth-1:0] RowCountReset    = CountWidth'(1048576);
   localparam logic [CountWidth-1:0] ColumnCountReset = CountWidth'(1048576);

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ROW_COUNT     = 2'd0,
      CSR_COLUMN_COUNT  = 2'd1,
      CSR_DEFAULT_VALUE = 2'd2
   } csr_index_type;

   // Request kinds
   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_WRITE  = 1'b1;

   // Response status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_COMPARE,
      ST_PROBE,
      ST_DECIDE,
      ST_SHIFT,
      ST_PLACE,
      ST_FINISH
   } state_type;

endpackage

// ----- sv/ssmt_entry_ram.sv -----
// Entry memory of the sorted sparse matrix table: one write port, one read port,
// read data registered. No dependencies.
module ssmt_entry_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sorted_sparse_matrix_table.sv -----
// Top level of the sorted sparse matrix table: control sequencer, registers and
// response stage. Depends on ssmt_pkg and ssmt_entry_ram.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_type, req_row_index, req_column_index,
//           |           |                       | req_write_value
//   rsp     | out       | rsp_valid/rsp_ready   | rsp_read_value, rsp_found, rsp_status
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// One request at a time. Out of range: from idle straight to the finish state. Lookup or
// update: a search and a compare state per binary search step (about log2(n+1) steps for
// n entries), the probe state when the lower bound slot is probed, then decide and finish.
// An insert moves entries up one per cycle (up to TABLE_DEPTH-1), set by the single write
// port of the entry memory, then places the new entry. Reset clears the entry count and the
// control registers; no clearing pass. A new request is taken while the previous response
// waits; a stalled response holds the next result in the finish state.
module sorted_sparse_matrix_table #(
   parameter int TABLE_DEPTH = ssmt_pkg::TableDepthDefault,
   parameter int INDEX_WIDTH = ssmt_pkg::IndexWidthDefault,
   parameter int VALUE_WIDTH = ssmt_pkg::ValueWidthDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic [INDEX_WIDTH-1:0]            req_row_index,
   input  logic [INDEX_WIDTH-1:0]            req_column_index,
   input  logic signed [VALUE_WIDTH-1:0]     req_write_value,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]     rsp_read_value,
   output logic                              rsp_found,
   output logic [1:0]                        rsp_status,
   // configuration channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ssmt_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [ssmt_pkg::CsrDataWidth-1:0]  csr_wdata
);

   localparam int AddrW  = $clog2(TABLE_DEPTH);
   localparam int CntW   = $clog2(TABLE_DEPTH + 1);
   localparam int KeyW   = 2 * INDEX_WIDTH;
   localparam int EntryW = KeyW + VALUE_WIDTH;
   localparam int CmpW   = (INDEX_WIDTH > ssmt_pkg::CountWidth) ? INDEX_WIDTH
                                                                 : ssmt_pkg::CountWidth;

   // configuration registers
   logic [ssmt_pkg::CountWidth-1:0] row_count_ff, column_count_ff;
   logic [VALUE_WIDTH-1:0]          default_value_ff;

   // sequencer state
   ssmt_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]        lo_ff, lo_in;
   logic [CntW-1:0]        hi_ff, hi_in;
   logic [AddrW-1:0]       src_ff, src_in;
   logic [CntW-1:0]        entry_count_ff, entry_count_in;
   logic                   hit_ff, hit_in;
   logic                   is_write_ff;
   logic [KeyW-1:0]        key_ff;
   logic [VALUE_WIDTH-1:0] wval_ff;
   logic [VALUE_WIDTH-1:0] res_value_ff, res_value_in;
   logic                   res_found_ff, res_found_in;
   logic [1:0]             res_status_ff, res_status_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic                   rsp_found_ff;
   logic [1:0]             rsp_status_ff;

   // memory port
   logic               rd_en, wr_en;
   logic [AddrW-1:0]   rd_addr, wr_addr;
   logic [EntryW-1:0]  rd_data, wr_data;
   logic [KeyW-1:0]    rd_key;
   logic [VALUE_WIDTH-1:0] rd_value;

   logic            req_accept, rsp_load, bad_coord;
   logic [CntW-1:0] mid;

   ssmt_entry_ram #(
      .DEPTH (TABLE_DEPTH),
      .WIDTH (EntryW)
   ) u_entry_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rd_key   = rd_data[EntryW-1:VALUE_WIDTH];
   assign rd_value = rd_data[VALUE_WIDTH-1:0];

   assign req_ready  = (state_ff == ssmt_pkg::ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ssmt_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign bad_coord = (CmpW'(req_row_index) >= CmpW'(row_count_ff)) ||
                      (CmpW'(req_column_index) >= CmpW'(column_count_ff));

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssmt_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = bad_coord ? ssmt_pkg::ST_FINISH : ssmt_pkg::ST_SEARCH;
            end
         end
         ssmt_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               state_in = ssmt_pkg::ST_COMPARE;
            end else if (lo_ff < entry_count_ff) begin
               state_in = ssmt_pkg::ST_PROBE;
            end else begin
               state_in = ssmt_pkg::ST_DECIDE;
            end
         end
         ssmt_pkg::ST_COMPARE: state_in = ssmt_pkg::ST_SEARCH;
         ssmt_pkg::ST_PROBE:   state_in = ssmt_pkg::ST_DECIDE;
         ssmt_pkg::ST_DECIDE: begin
            if (!is_write_ff || hit_ff || entry_count_ff == CntW'(TABLE_DEPTH)) begin
               state_in = ssmt_pkg::ST_FINISH;
            end else if (entry_count_ff > lo_ff) begin
               state_in = ssmt_pkg::ST_SHIFT;
            end else begin
               state_in = ssmt_pkg::ST_PLACE;
            end
         end
         ssmt_pkg::ST_SHIFT: begin
            if (CntW'(src_ff) <= lo_ff) begin
               state_in = ssmt_pkg::ST_PLACE;
            end
         end
         ssmt_pkg::ST_PLACE: state_in = ssmt_pkg::ST_FINISH;
         ssmt_pkg::ST_FINISH: begin
            if (rsp_load) begin
               state_in = ssmt_pkg::ST_IDLE;
            end
         end
         default: state_in = ssmt_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      src_in         = src_ff;
      hit_in         = hit_ff;
      entry_count_in = entry_count_ff;
      res_value_in   = res_value_ff;
      res_found_in   = res_found_ff;
      res_status_in  = res_status_ff;
      rd_en          = 1'b0;
      rd_addr        = mid[AddrW-1:0];
      wr_en          = 1'b0;
      wr_addr        = lo_ff[AddrW-1:0];
      wr_data        = {key_ff, wval_ff};
      unique case (state_ff)
         ssmt_pkg::ST_IDLE: begin
            lo_in         = '0;
            hi_in         = entry_count_ff;
            hit_in        = 1'b0;
            res_value_in  = default_value_ff;
            res_found_in  = 1'b0;
            res_status_in = bad_coord ? ssmt_pkg::STATUS_RANGE : ssmt_pkg::STATUS_OK;
         end
         ssmt_pkg::ST_SEARCH: begin
            if (lo_ff < hi_ff) begin
               rd_en = 1'b1;
            end else if (lo_ff < entry_count_ff) begin
               // probe the lower bound slot for an exact match
               rd_en   = 1'b1;
               rd_addr = lo_ff[AddrW-1:0];
            end
         end
         ssmt_pkg::ST_COMPARE: begin
            if (rd_key < key_ff) begin
               lo_in = mid + CntW'(1);
            end else begin
               hi_in = mid;
            end
         end
         ssmt_pkg::ST_PROBE: begin
            hit_in = (rd_key == key_ff);
         end
         ssmt_pkg::ST_DECIDE: begin
            if (!is_write_ff) begin
               if (hit_ff) begin
                  res_value_in = rd_value;
                  res_found_in = 1'b1;
               end
            end else if (hit_ff) begin
               wr_en        = 1'b1;
               res_value_in = wval_ff;
               res_found_in = 1'b1;
            end else if (entry_count_ff == CntW'(TABLE_DEPTH)) begin
               res_status_in = ssmt_pkg::STATUS_FULL;
            end else if (entry_count_ff > lo_ff) begin
               // start the move at the last valid entry
               rd_en   = 1'b1;
               rd_addr = AddrW'(entry_count_ff - CntW'(1));
               src_in  = AddrW'(entry_count_ff - CntW'(1));
            end
         end
         ssmt_pkg::ST_SHIFT: begin
            // move the entry read last cycle up one slot, read the next one down
            wr_en   = 1'b1;
            wr_addr = src_ff + AddrW'(1);
            wr_data = rd_data;
            if (CntW'(src_ff) > lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = src_ff - AddrW'(1);
               src_in  = src_ff - AddrW'(1);
            end
         end
         ssmt_pkg::ST_PLACE: begin
            wr_en          = 1'b1;
            entry_count_in = entry_count_ff + CntW'(1);
            res_value_in   = wval_ff;
         end
         ssmt_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ssmt_pkg::ST_IDLE;
         entry_count_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
         row_count_ff     <= ssmt_pkg::RowCountReset;
         column_count_ff  <= ssmt_pkg::ColumnCountReset;
         default_value_ff <= '0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               ssmt_pkg::CSR_ROW_COUNT:
                  row_count_ff <= csr_wdata[ssmt_pkg::CountWidth-1:0];
               ssmt_pkg::CSR_COLUMN_COUNT:
                  column_count_ff <= csr_wdata[ssmt_pkg::CountWidth-1:0];
               ssmt_pkg::CSR_DEFAULT_VALUE:
                  default_value_ff <= VALUE_WIDTH'(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      src_ff        <= src_in;
      hit_ff        <= hit_in;
      res_value_ff  <= res_value_in;
      res_found_ff  <= res_found_in;
      res_status_ff <= res_status_in;
      if (req_accept) begin
         is_write_ff <= (req_type == ssmt_pkg::REQ_WRITE);
         key_ff      <= {req_row_index, req_column_index};
         wval_ff     <= req_write_value;
      end
      if (rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_status     = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CntW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ssmt_pkg::STATUS_OK)
      else $error("found set on a failed request");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != ssmt_pkg::ST_IDLE)
      else $error("sequencer idle after taking a request");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff != $past(entry_count_ff) |->
         $past(state_ff) == ssmt_pkg::ST_PLACE || $past(reset))
      else $error("entry count changed outside of an insert");

endmodule
